@@ sv/unlap_pkg.sv @@
// Shared widths, stage counts and axis codes for the largest-axis normal packer.
package unlap_pkg;

   localparam int COMP_BITS = 16;              // width of one signed input component
   localparam int MAG_W     = COMP_BITS;       // magnitude of a component, unsigned
   localparam int DEN_W     = MAG_W + 1;       // divisor 2*|max|
   localparam int NUM_W     = COMP_BITS + 10;  // dividend 513*|max| + 510*c, never negative
   localparam int QUOT_W    = 9;               // one code
   localparam int NSTG      = QUOT_W + 2;      // select, dividend, one stage per code bit
   localparam int PAD_W     = 10;              // zero bits at the bottom of the word
   localparam int PACK_W    = 2 + 1 + 2 * QUOT_W + PAD_W;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

endpackage

@@ sv/unit_normal_largest_axis_pack.sv @@
// Pipelined largest-axis normal packer: axis select, dividend build, restoring divide.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_comp_x, req_comp_y, req_comp_z
//   rsp      out        rsp_valid/rsp_stall  rsp_packed_word
//
// One word enters per cycle while req_stall is low, and each word passes through the stages in turn:
// one registered compare-subtract per code bit (nine) in the divider, after a stage that
// picks the axis and a stage that forms the dividends.
// Every stage holds its own valid bit and moves whenever the stage after it is
// free or moving, so bubbles close up and a stalled output still lets words in.
// Reset clears the valid bits only; the pipeline is empty and ready afterwards.
module unit_normal_largest_axis_pack
   import unlap_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COMP_BITS-1:0] req_comp_x,
   input  logic signed [COMP_BITS-1:0] req_comp_y,
   input  logic signed [COMP_BITS-1:0] req_comp_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic        [PACK_W-1:0]    rsp_packed_word
);

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] ready_s;

   axis_type ax_ff [NSTG];
   logic     sg_ff [NSTG];

   // stage 0 registers
   logic signed [COMP_BITS-1:0] ch_ff, cl_ff;
   logic        [MAG_W-1:0]     d_ff;

   // dividend/remainder chain: index 0 is the dividend stage, index j+1 is divide step j
   logic [NUM_W-1:0] rem_hi_ff [QUOT_W+1];
   logic [NUM_W-1:0] rem_lo_ff [QUOT_W+1];
   logic [DEN_W-1:0] den_ff    [QUOT_W+1];
   logic [QUOT_W-1:0] q_hi_ff  [QUOT_W];
   logic [QUOT_W-1:0] q_lo_ff  [QUOT_W];

   // ---------------------------------------------------------------- flow control
   always_comb begin
      ready_s[NSTG-1] = !valid_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         ready_s[k] = !valid_ff[k] || ready_s[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !ready_s[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (ready_s[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 0: pick axis
   logic [MAG_W-1:0] ax_mag, ay_mag, az_mag, d_sel;
   logic signed [COMP_BITS-1:0] ch_in, cl_in;
   axis_type ax_in;
   logic     sg_in;
   logic [MAG_W-1:0] d_in;

   always_comb begin
      ax_mag = req_comp_x[COMP_BITS-1] ? MAG_W'(~req_comp_x + 1'b1) : MAG_W'(req_comp_x);
      ay_mag = req_comp_y[COMP_BITS-1] ? MAG_W'(~req_comp_y + 1'b1) : MAG_W'(req_comp_y);
      az_mag = req_comp_z[COMP_BITS-1] ? MAG_W'(~req_comp_z + 1'b1) : MAG_W'(req_comp_z);

      if (ax_mag >= ay_mag && ax_mag >= az_mag) begin
         ax_in = AXIS_X;
      end else if (ay_mag >= az_mag) begin
         ax_in = AXIS_Y;
      end else begin
         ax_in = AXIS_Z;
      end

      case (ax_in)
         AXIS_Y: begin
            ch_in = req_comp_z;
            cl_in = req_comp_x;
            d_sel = ay_mag;
            sg_in = req_comp_y[COMP_BITS-1];
         end
         AXIS_Z: begin
            ch_in = req_comp_x;
            cl_in = req_comp_y;
            d_sel = az_mag;
            sg_in = req_comp_z[COMP_BITS-1];
         end
         default: begin
            ch_in = req_comp_y;
            cl_in = req_comp_z;
            d_sel = ax_mag;
            sg_in = req_comp_x[COMP_BITS-1];
         end
      endcase

      // all-zero vector: divide 513 by 2 so both codes come out as the midpoint
      d_in = (d_sel == '0) ? MAG_W'(1) : d_sel;
   end

   always_ff @(posedge clock) begin
      if (ready_s[0]) begin
         ch_ff    <= ch_in;
         cl_ff    <= cl_in;
         d_ff     <= d_in;
         ax_ff[0] <= ax_in;
         sg_ff[0] <= sg_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: dividends
   // code = floor((513*d + 510*c) / (2*d)); with |c| <= d the dividend stays positive
   logic signed [NUM_W:0] d_s, ch_s, cl_s, num_hi, num_lo;

   always_comb begin
      d_s    = signed'((NUM_W + 1)'(d_ff));
      ch_s   = (NUM_W + 1)'(ch_ff);
      cl_s   = (NUM_W + 1)'(cl_ff);
      num_hi = (d_s <<< 9) + d_s + (ch_s <<< 9) - (ch_s <<< 1);
      num_lo = (d_s <<< 9) + d_s + (cl_s <<< 9) - (cl_s <<< 1);
   end

   always_ff @(posedge clock) begin
      if (ready_s[1]) begin
         rem_hi_ff[0] <= num_hi[NUM_W-1:0];
         rem_lo_ff[0] <= num_lo[NUM_W-1:0];
         den_ff[0]    <= {d_ff, 1'b0};
         ax_ff[1]     <= ax_ff[0];
         sg_ff[1]     <= sg_ff[0];
      end
   end

   // ---------------------------------------------------------------- stages 2..: divide
   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      localparam int SH = QUOT_W - 1 - j;

      logic [NUM_W-1:0]  trial;
      logic              ge_hi, ge_lo;
      logic [NUM_W-1:0]  rem_hi_in, rem_lo_in;
      logic [QUOT_W-1:0] q_hi_prev, q_lo_prev, q_hi_in, q_lo_in;

      if (j == 0) begin : g_first
         assign q_hi_prev = '0;
         assign q_lo_prev = '0;
      end else begin : g_next
         assign q_hi_prev = q_hi_ff[j-1];
         assign q_lo_prev = q_lo_ff[j-1];
      end

      always_comb begin
         trial     = NUM_W'(den_ff[j]) << SH;
         ge_hi     = rem_hi_ff[j] >= trial;
         ge_lo     = rem_lo_ff[j] >= trial;
         rem_hi_in = ge_hi ? rem_hi_ff[j] - trial : rem_hi_ff[j];
         rem_lo_in = ge_lo ? rem_lo_ff[j] - trial : rem_lo_ff[j];
         q_hi_in     = q_hi_prev;
         q_lo_in     = q_lo_prev;
         q_hi_in[SH] = ge_hi;
         q_lo_in[SH] = ge_lo;
      end

      always_ff @(posedge clock) begin
         if (ready_s[j+2]) begin
            rem_hi_ff[j+1] <= rem_hi_in;
            rem_lo_ff[j+1] <= rem_lo_in;
            den_ff[j+1]    <= den_ff[j];
            q_hi_ff[j]     <= q_hi_in;
            q_lo_ff[j]     <= q_lo_in;
            ax_ff[j+2]     <= ax_ff[j+1];
            sg_ff[j+2]     <= sg_ff[j+1];
         end
      end
   end

   // ---------------------------------------------------------------- output word
   assign rsp_valid       = valid_ff[NSTG-1];
   assign rsp_packed_word = {ax_ff[NSTG-1], sg_ff[NSTG-1],
                             q_hi_ff[QUOT_W-1], q_lo_ff[QUOT_W-1], PAD_W'(0)};

`ifndef SYNTHESIS
   // the divisor stage never sees a zero magnitude
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> d_ff != '0)
      else $error("zero divisor entered the divider");

   // first quotient bit step leaves a remainder below 2*d*256, so the code fits 9 bits
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> rem_hi_ff[1] < (NUM_W'(den_ff[1]) << (QUOT_W - 1))
                   && rem_lo_ff[1] < (NUM_W'(den_ff[1]) << (QUOT_W - 1)))
      else $error("quotient overflows code width");

   // after the last step the remainder is below the divisor
   a_rem_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rem_hi_ff[QUOT_W] < NUM_W'(den_ff[QUOT_W])
                 && rem_lo_ff[QUOT_W] < NUM_W'(den_ff[QUOT_W]))
      else $error("divider remainder not reduced");

   // codes lie in 1..511
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> q_hi_ff[QUOT_W-1] != '0 && q_lo_ff[QUOT_W-1] != '0)
      else $error("code out of range");

   // a stalled output stage keeps the stage behind it frozen when that stage is full
   a_back_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTG-1] && rsp_stall && valid_ff[NSTG-2] |=> valid_ff[NSTG-2]
         && $stable(q_hi_ff[QUOT_W-2]))
      else $error("word lost behind stalled output");
`endif

endmodule

@@ tb/tb_unit_normal_largest_axis_pack.sv @@
// Self-checking testbench for the largest-axis normal packer, with directed and random vectors.
`timescale 1ns / 100ps

module tb_unit_normal_largest_axis_pack
   import unlap_pkg::*;
();

   typedef logic signed [COMP_BITS-1:0] comp_type;
   typedef logic [PACK_W-1:0] pack_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     known;
      pack_type word;
   } stim_row_type;

   localparam int RAND_ITEMS  = 500;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 40;
   localparam int HOLD_CYCLES = 300;
   localparam comp_type MOST_POS = 16'sh7fff;
   localparam comp_type MOST_NEG = 16'sh8000;

   // Directed vectors; the word is typed in only where it is plain to read off.
   localparam int DIR_N = 22;
   localparam stim_row_type DIR_ROWS [DIR_N] = '{
      '{16'sd0,    16'sd0,    16'sd0,    1'b1, {AXIS_X, 1'b0, 9'd256, 9'd256, 10'd0}},
      '{MOST_POS,  16'sd0,    16'sd0,    1'b1, {AXIS_X, 1'b0, 9'd256, 9'd256, 10'd0}},
      '{MOST_NEG,  16'sd0,    16'sd0,    1'b1, {AXIS_X, 1'b1, 9'd256, 9'd256, 10'd0}},
      '{16'sd0,    MOST_POS,  16'sd0,    1'b1, {AXIS_Y, 1'b0, 9'd256, 9'd256, 10'd0}},
      '{16'sd0,    MOST_NEG,  16'sd0,    1'b1, {AXIS_Y, 1'b1, 9'd256, 9'd256, 10'd0}},
      '{16'sd0,    16'sd0,    MOST_POS,  1'b1, {AXIS_Z, 1'b0, 9'd256, 9'd256, 10'd0}},
      '{16'sd0,    16'sd0,    MOST_NEG,  1'b1, {AXIS_Z, 1'b1, 9'd256, 9'd256, 10'd0}},
      '{MOST_POS,  MOST_POS,  MOST_POS,  1'b1, {AXIS_X, 1'b0, 9'd511, 9'd511, 10'd0}},
      '{MOST_NEG,  MOST_NEG,  MOST_NEG,  1'b1, {AXIS_X, 1'b1, 9'd1,   9'd1,   10'd0}},
      '{MOST_NEG,  MOST_POS,  -16'sd32767, 1'b0, 31'd0},
      '{MOST_POS,  MOST_NEG,  16'sd0,    1'b0, 31'd0},
      '{16'sd0,    -16'sd7,   16'sd7,    1'b1, {AXIS_Y, 1'b1, 9'd511, 9'd256, 10'd0}},
      '{-16'sd5,   16'sd5,    16'sd0,    1'b1, {AXIS_X, 1'b1, 9'd511, 9'd256, 10'd0}},
      '{16'sd2,    16'sd1,    16'sd0,    1'b1, {AXIS_X, 1'b0, 9'd384, 9'd256, 10'd0}},
      '{16'sd2,    -16'sd1,   16'sd1,    1'b1, {AXIS_X, 1'b0, 9'd129, 9'd384, 10'd0}},
      '{16'sd1,    -16'sd1,   16'sd1,    1'b1, {AXIS_X, 1'b0, 9'd1,   9'd511, 10'd0}},
      '{16'sd0,    16'sd0,    16'sd1,    1'b1, {AXIS_Z, 1'b0, 9'd256, 9'd256, 10'd0}},
      '{-16'sd1,   16'sd0,    16'sd0,    1'b1, {AXIS_X, 1'b1, 9'd256, 9'd256, 10'd0}},
      '{16'sd1000, -16'sd3,   16'sd30000, 1'b0, 31'd0},
      '{-16'sd12345, 16'sd20000, -16'sd19999, 1'b0, 31'd0},
      '{16'sh5555, 16'shaaaa, 16'sh0f0f, 1'b0, 31'd0},
      '{16'shaaaa, 16'sh5555, MOST_POS,  1'b0, 31'd0}
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   comp_type req_comp_x = '0;
   comp_type req_comp_y = '0;
   comp_type req_comp_z = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   pack_type rsp_packed_word;

   pack_type packed_due [$];
   int       fault_count = 0;
   int       vec_taken = 0;
   int       idle_cycles = 0;

   unit_normal_largest_axis_pack u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_comp_x      (req_comp_x),
      .req_comp_y      (req_comp_y),
      .req_comp_z      (req_comp_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_word (rsp_packed_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // round_half_up(256 + 255*c/d), done as (513*d + 510*c) / (2*d)
   function automatic logic [QUOT_W-1:0] scaled_code(longint c, longint d);
      longint q;
      q = (513 * d + 510 * c) / (2 * d);
      return q[QUOT_W-1:0];
   endfunction

   function automatic pack_type pack_normal(comp_type vx, comp_type vy, comp_type vz);
      longint comp [3];
      longint magn [3];
      axis_type ax;
      int idx;
      longint dmax;
      logic sgn;
      logic [QUOT_W-1:0] code_hi, code_lo;
      comp[0] = vx;
      comp[1] = vy;
      comp[2] = vz;
      for (int i = 0; i < 3; i++) magn[i] = (comp[i] < 0) ? -comp[i] : comp[i];
      if (magn[0] >= magn[1] && magn[0] >= magn[2]) ax = AXIS_X;
      else if (magn[1] >= magn[2]) ax = AXIS_Y;
      else ax = AXIS_Z;
      idx = int'(ax);
      dmax = magn[idx];
      sgn = comp[idx] < 0;
      if (dmax == 0) begin
         code_hi = 9'd256;
         code_lo = 9'd256;
      end else begin
         // the two kept components follow the dropped axis cyclically
         code_hi = scaled_code(comp[(idx + 1) % 3], dmax);
         code_lo = scaled_code(comp[(idx + 2) % 3], dmax);
      end
      return {ax, sgn, code_hi, code_lo, {PAD_W{1'b0}}};
   endfunction

   // Sender: directed rows, then shaped random vectors, in bursts with gaps.
   initial begin
      stim_row_type row;
      comp_type v [3];
      comp_type t;
      int rot, kind, burst_left;
      burst_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int n = 0; n < DIR_N + RAND_ITEMS; n++) begin
         if (n < DIR_N) begin
            row = DIR_ROWS[n];
         end else begin
            kind = $urandom_range(0, 9);
            case (kind)
               0, 1, 2: begin
                  for (int i = 0; i < 3; i++) v[i] = comp_type'($urandom);
               end
               3: begin
                  // tiny values hit the exact-half rounding often
                  for (int i = 0; i < 3; i++)
                     v[i] = comp_type'(int'($urandom_range(0, 8)) - 4);
               end
               4, 5: begin
                  // equal magnitudes on two axes
                  t = comp_type'($urandom);
                  v[0] = t;
                  v[1] = $urandom_range(0, 1) ? -t : t;
                  v[2] = comp_type'($urandom) >>> $urandom_range(0, 15);
               end
               6: begin
                  v[0] = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
                  v[1] = comp_type'($urandom);
                  v[2] = comp_type'($urandom);
               end
               7: begin
                  for (int i = 0; i < 3; i++)
                     v[i] = comp_type'(int'($urandom_range(0, 2000)) - 1000);
               end
               default: begin
                  for (int i = 0; i < 3; i++)
                     v[i] = $urandom_range(0, 2) == 0 ? comp_type'($urandom) : comp_type'(0);
               end
            endcase
            rot = $urandom_range(0, 2);
            row.x = v[rot];
            row.y = v[(rot + 1) % 3];
            row.z = v[(rot + 2) % 3];
            row.known = 1'b0;
            row.word = '0;
         end
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         req_valid <= 1'b1;
         req_comp_x <= row.x;
         req_comp_y <= row.y;
         req_comp_z <= row.z;
         do @(posedge clock); while (req_stall);
         packed_due.push_back(row.known ? row.word : pack_normal(row.x, row.y, row.z));
         vec_taken++;
         burst_left--;
      end
      req_valid <= 1'b0;
      while (packed_due.size() != 0) @(posedge clock);
      // let any stray word out of the eleven-stage pipe
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fault_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Receiver: phases of free flow, random and alternating stalls, one long hold.
   initial begin
      int mode, span;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && vec_taken >= 40) begin
            // hold the output so the pipe fills and stalls its input
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(0, 1) == 1;
               2: rsp_stall <= ~rsp_stall;
               default: rsp_stall <= $urandom_range(0, 9) < 8;
            endcase
            @(posedge clock);
         end
      end
   end

   // Check each output word against the oldest prediction; watch for a hang.
   always @(posedge clock) begin
      pack_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (packed_due.size() == 0) begin
               $error("packed_word: expected none, actual %h", rsp_packed_word);
               fault_count++;
            end else begin
               want = packed_due.pop_front();
               if (rsp_packed_word !== want) begin
                  $error("packed_word: expected %h, actual %h", want, rsp_packed_word);
                  fault_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
